FILE: hdl/fsw_pkg.sv
// shared types, constants and tables for the fourier series waveform evaluator
package fsw_pkg;

   localparam int TIME_W     = 16;
   localparam int SQ_W       = 20;
   localparam int IV_W       = 32;
   localparam int HC_W       = 6;
   localparam int IRC_W      = 16;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [0:0] {
      CSR_HARMONIC_COUNT = 1'b0,
      CSR_INVERSE_RC     = 1'b1
   } csr_index_type;

   localparam logic [HC_W-1:0]  HC_RESET  = 6'd20;
   localparam logic [IRC_W-1:0] IRC_RESET = 16'd100;

   localparam int CORDIC_STEPS = 16;
   localparam int CW           = 34;
   localparam int MAG_W        = 31;
   localparam int TERM_W       = 32;
   localparam int MAGIC_W      = 32;

   localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;
   localparam logic signed [23:0]   INV_PI_Q24  = 24'sd5340354;
   localparam logic signed [21:0]   INV_PI2_Q24 = 22'sd1699887;

   function automatic logic signed [CW-1:0] arc_step(input int unsigned i);
      logic signed [CW-1:0] a;
      unique case (i)
         0:       a = 34'sd536870912;
         1:       a = 34'sd316933406;
         2:       a = 34'sd167458907;
         3:       a = 34'sd85004756;
         4:       a = 34'sd42667331;
         5:       a = 34'sd21354465;
         6:       a = 34'sd10679838;
         7:       a = 34'sd5340245;
         8:       a = 34'sd2670163;
         9:       a = 34'sd1335087;
         10:      a = 34'sd667544;
         11:      a = 34'sd333772;
         12:      a = 34'sd166886;
         13:      a = 34'sd83443;
         14:      a = 34'sd41722;
         15:      a = 34'sd20861;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

FILE: hdl/fsw_req_if.sv
// time phase word channel
interface fsw_req_if;
   logic                          valid;
   logic                          ready;
   logic [fsw_pkg::TIME_W-1:0]    time_phase;

   modport source (output valid, output time_phase, input ready);
   modport sink   (input valid, input time_phase, output ready);
endinterface

FILE: hdl/fsw_rsp_if.sv
// waveform result word channel
interface fsw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [fsw_pkg::SQ_W-1:0]   square_value;
   logic signed [fsw_pkg::IV_W-1:0]   integrated_value;

   modport source (output valid, output square_value, output integrated_value, input ready);
   modport sink   (input valid, input square_value, input integrated_value, output ready);
endinterface

FILE: hdl/fourier_series_waveform_eval.sv
// fourier series square wave and rc-integrated wave evaluator, top level
//
// Takes one time phase word per clock and returns one word per clock holding the
// truncated square wave sum and its rc-integrated sum, as long as rsp_ch.ready is
// high. Every odd harmonic has its own 16-stage cordic lane, the lanes feed a
// registered adder tree and a short scaling pipeline, so the rate is one word per
// cycle unless the result stalls. A stalled result holds the whole pipeline only once
// every stage is full. harmonic_count and inverse_rc are written through the csr port
// while idle; the user must keep to this, the block itself does not enforce it.
module fourier_series_waveform_eval #(
   parameter int MAX_HARMONICS = 32,
   parameter int PHASE_BITS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   fsw_req_if.sink                       req_ch,
   fsw_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  fsw_pkg::csr_index_type        csr_index,
   input  logic [fsw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fsw_pkg::*;

   localparam int LANES       = (MAX_HARMONICS + 1) / 2;
   localparam int TREE_LEVELS = $clog2(LANES);
   localparam int LEAVES      = 2 ** TREE_LEVELS;
   localparam int NODES       = 2 * LEAVES - 1;
   localparam int SUM_W       = TERM_W + TREE_LEVELS;
   localparam int APW         = SUM_W + 24;
   localparam int BPW         = SUM_W + 22;
   localparam int P_W         = BPW - 20;
   localparam int IPW         = P_W + IRC_W + 1;

   localparam int S_FOLD  = 1;
   localparam int S_MUL   = S_FOLD + CORDIC_STEPS + 1;
   localparam int S_TERM  = S_MUL + 1;
   localparam int S_ROOT  = S_TERM + TREE_LEVELS;
   localparam int S_K     = S_ROOT + 1;
   localparam int S_RND   = S_ROOT + 2;
   localparam int S_RC    = S_ROOT + 3;
   localparam int S_OUT   = S_ROOT + 4;
   localparam int NSTAGES = S_OUT + 1;

   localparam logic signed [APW-1:0] SQ_HI = APW'((64'sd1 <<< (SQ_W - 1)) - 64'sd1);
   localparam logic signed [APW-1:0] SQ_LO = APW'(-(64'sd1 <<< (SQ_W - 1)));
   localparam logic signed [IPW-1:0] IV_HI = IPW'((64'sd1 <<< (IV_W - 1)) - 64'sd1);
   localparam logic signed [IPW-1:0] IV_LO = IPW'(-(64'sd1 <<< (IV_W - 1)));

   // configuration
   logic [HC_W-1:0]  hc_ff;
   logic [IRC_W-1:0] irc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff  <= HC_RESET;
         irc_ff <= IRC_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HARMONIC_COUNT: hc_ff  <= csr_wdata[HC_W-1:0];
            CSR_INVERSE_RC:     irc_ff <= csr_wdata[IRC_W-1:0];
         endcase
      end
   end

   // stage valids and enables
   logic [NSTAGES-1:0] v_ff;
   logic [NSTAGES-1:0] v_in;
   logic [NSTAGES-1:0] en;

   always_comb begin
      en[NSTAGES-1] = !v_ff[NSTAGES-1] || rsp_ch.ready;
      for (int i = NSTAGES - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign v_in = {v_ff[NSTAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_in & en) | (v_ff & ~en);
      end
   end

   assign req_ch.ready = en[0];

   // phase rescale
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_ff;

   if (PHASE_BITS >= TIME_W) begin : g_ph_up
      assign phase_in = PHASE_BITS'({req_ch.time_phase, {(PHASE_BITS - TIME_W + 1){1'b0}}} >> 1);
   end else begin : g_ph_down
      assign phase_in = req_ch.time_phase[TIME_W-1 -: PHASE_BITS];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         phase_ff <= phase_in;
      end
   end

   // adder tree, heap order, leaves at the end
   logic signed [SUM_W-1:0] node_sq  [0:NODES-1];
   logic signed [SUM_W-1:0] node_int [0:NODES-1];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      localparam int N     = 2 * k + 1;
      localparam bit NEG_N = (N % 4) == 3;
      localparam int DS    = N * N;
      localparam int LC    = $clog2(N);
      localparam int LS    = $clog2(DS);
      localparam int SHC   = MAG_W + LC;
      localparam int SHS   = MAG_W + LS;
      localparam logic [MAGIC_W-1:0] MC =
         MAGIC_W'(((64'd1 << SHC) + 64'(N) - 64'd1) / 64'(N));
      localparam logic [MAGIC_W-1:0] MS =
         MAGIC_W'(((64'd1 << SHS) + 64'(DS) - 64'd1) / 64'(DS));
      localparam logic [HC_W:0] NV = (HC_W + 1)'(N);

      logic [PHASE_BITS-1:0]   pm;
      logic [31:0]             ang;
      logic [31:0]             ang_q;
      logic                    flip;
      logic [31:0]             fold;
      logic signed [CW-1:0]    z_ff    [0:CORDIC_STEPS-1];
      logic signed [CW-1:0]    x_ff    [1:CORDIC_STEPS];
      logic signed [CW-1:0]    y_ff    [1:CORDIC_STEPS];
      logic                    flip_ff [0:CORDIC_STEPS];

      assign pm    = PHASE_BITS'(phase_ff * N);
      assign ang   = {pm, {(32 - PHASE_BITS){1'b0}}};
      assign ang_q = ang + 32'h4000_0000;
      assign flip  = ang_q[31];
      assign fold  = {ang[31] ^ flip, ang[30:0]};

      always_ff @(posedge clock) begin
         if (en[S_FOLD]) begin
            z_ff[0]    <= CW'($signed(fold));
            flip_ff[0] <= flip;
         end
      end

      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         logic signed [CW-1:0] x_cur;
         logic signed [CW-1:0] y_cur;

         if (i == 0) begin : g_first
            assign x_cur = CORDIC_K;
            assign y_cur = '0;
         end else begin : g_next
            assign x_cur = x_ff[i];
            assign y_cur = y_ff[i];
         end

         always_ff @(posedge clock) begin
            if (en[S_FOLD+1+i]) begin
               flip_ff[i+1] <= flip_ff[i];
               if (z_ff[i] >= 0) begin
                  x_ff[i+1] <= x_cur - (y_cur >>> i);
                  y_ff[i+1] <= y_cur + (x_cur >>> i);
               end else begin
                  x_ff[i+1] <= x_cur + (y_cur >>> i);
                  y_ff[i+1] <= y_cur - (x_cur >>> i);
               end
            end
         end

         if (i < CORDIC_STEPS - 1) begin : g_z
            always_ff @(posedge clock) begin
               if (en[S_FOLD+1+i]) begin
                  if (z_ff[i] >= 0) begin
                     z_ff[i+1] <= z_ff[i] - arc_step(i);
                  end else begin
                     z_ff[i+1] <= z_ff[i] + arc_step(i);
                  end
               end
            end
         end
      end

      // divide by n and n*n through reciprocal multiply
      logic signed [CW-1:0]          xa;
      logic signed [CW-1:0]          ya;
      logic [MAG_W+MAGIC_W-1:0]      mul_c_ff;
      logic [MAG_W+MAGIC_W-1:0]      mul_s_ff;
      logic                          neg_c_ff;
      logic                          neg_s_ff;
      logic [MAG_W-1:0]              q_c;
      logic [MAG_W-1:0]              q_s;
      logic signed [TERM_W-1:0]      term_c;
      logic signed [TERM_W-1:0]      term_s;
      logic                          used;

      assign xa = x_ff[CORDIC_STEPS][CW-1] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      assign ya = y_ff[CORDIC_STEPS][CW-1] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];

      always_ff @(posedge clock) begin
         if (en[S_MUL]) begin
            mul_c_ff <= (MAG_W + MAGIC_W)'(xa[MAG_W-1:0]) * (MAG_W + MAGIC_W)'(MC);
            mul_s_ff <= (MAG_W + MAGIC_W)'(ya[MAG_W-1:0]) * (MAG_W + MAGIC_W)'(MS);
            neg_c_ff <= NEG_N ^ flip_ff[CORDIC_STEPS] ^ x_ff[CORDIC_STEPS][CW-1];
            neg_s_ff <= NEG_N ^ flip_ff[CORDIC_STEPS] ^ y_ff[CORDIC_STEPS][CW-1];
         end
      end

      assign q_c    = MAG_W'(mul_c_ff >> SHC);
      assign q_s    = MAG_W'(mul_s_ff >> SHS);
      assign term_c = neg_c_ff ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
      assign term_s = neg_s_ff ? -$signed({1'b0, q_s}) : $signed({1'b0, q_s});
      assign used   = {1'b0, hc_ff} >= NV;

      always_ff @(posedge clock) begin
         if (en[S_TERM]) begin
            node_sq[LEAVES-1+k]  <= used ? SUM_W'(term_c) : '0;
            node_int[LEAVES-1+k] <= used ? SUM_W'(term_s) : '0;
         end
      end
   end

   for (genvar k = LANES; k < LEAVES; k++) begin : g_pad
      always_ff @(posedge clock) begin
         if (en[S_TERM]) begin
            node_sq[LEAVES-1+k]  <= '0;
            node_int[LEAVES-1+k] <= '0;
         end
      end
   end

   for (genvar j = 0; j < LEAVES - 1; j++) begin : g_node
      localparam int D  = $clog2(j + 2) - 1;
      localparam int ST = S_TERM + TREE_LEVELS - D;

      always_ff @(posedge clock) begin
         if (en[ST]) begin
            node_sq[j]  <= node_sq[2*j+1] + node_sq[2*j+2];
            node_int[j] <= node_int[2*j+1] + node_int[2*j+2];
         end
      end
   end

   // scaling and saturation
   logic signed [APW-1:0]  a_prod_ff;
   logic signed [BPW-1:0]  b_prod_ff;
   logic signed [APW-1:0]  sq_rnd;
   logic signed [APW-1:0]  sq_sh;
   logic signed [BPW-1:0]  p_rnd;
   logic signed [BPW-1:0]  p_sh;
   logic signed [SQ_W-1:0] sq_ff;
   logic signed [SQ_W-1:0] sq_rc_ff;
   logic signed [SQ_W-1:0] sq_out_ff;
   logic signed [P_W-1:0]  p_ff;
   logic signed [IPW-1:0]  iv_prod_ff;
   logic signed [IPW-1:0]  iv_rnd;
   logic signed [IPW-1:0]  iv_sh;
   logic signed [IV_W-1:0] iv_out_ff;

   always_ff @(posedge clock) begin
      if (en[S_K]) begin
         a_prod_ff <= node_sq[0] * INV_PI_Q24;
         b_prod_ff <= node_int[0] * INV_PI2_Q24;
      end
   end

   assign sq_rnd = a_prod_ff + (APW'(1) <<< 37);
   assign sq_sh  = sq_rnd >>> 38;
   assign p_rnd  = b_prod_ff + (BPW'(1) <<< 19);
   assign p_sh   = p_rnd >>> 20;

   always_ff @(posedge clock) begin
      if (en[S_RND]) begin
         if (sq_sh > SQ_HI) begin
            sq_ff <= SQ_HI[SQ_W-1:0];
         end else if (sq_sh < SQ_LO) begin
            sq_ff <= SQ_LO[SQ_W-1:0];
         end else begin
            sq_ff <= sq_sh[SQ_W-1:0];
         end
         p_ff <= p_sh[P_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_RC]) begin
         iv_prod_ff <= IPW'(p_ff) * IPW'($signed({1'b0, irc_ff}));
         sq_rc_ff   <= sq_ff;
      end
   end

   assign iv_rnd = iv_prod_ff + (IPW'(1) <<< 17);
   assign iv_sh  = iv_rnd >>> 18;

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         sq_out_ff <= sq_rc_ff;
         if (iv_sh > IV_HI) begin
            iv_out_ff <= IV_HI[IV_W-1:0];
         end else if (iv_sh < IV_LO) begin
            iv_out_ff <= IV_LO[IV_W-1:0];
         end else begin
            iv_out_ff <= iv_sh[IV_W-1:0];
         end
      end
   end

   assign rsp_ch.valid            = v_ff[NSTAGES-1];
   assign rsp_ch.square_value     = sq_out_ff;
   assign rsp_ch.integrated_value = iv_out_ff;

   // checks
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&v_ff) && !rsp_ch.ready)
      else $error("input stalled while the pipeline has room");

   a_zero_count_leaf: assert property (@(posedge clock) disable iff (reset)
      en[S_TERM] && v_ff[S_TERM-1] && hc_ff == '0 |=>
         node_sq[LEAVES-1] == '0 && node_int[LEAVES-1] == '0)
      else $error("harmonic included with zero harmonic count");

   a_config_reset: assert property (@(posedge clock)
      $past(reset) |-> hc_ff == HC_RESET && irc_ff == IRC_RESET)
      else $error("configuration not at reset values");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(sq_out_ff) &&
         $stable(iv_out_ff))
      else $error("stalled result word changed");

endmodule

FILE: verif/tb.sv
// self-checking testbench for the fourier series waveform evaluator
module tb;
   import fsw_pkg::*;

   typedef struct packed {
      logic signed [SQ_W-1:0] square_value;
      logic signed [IV_W-1:0] integrated_value;
   } wave_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_HARMONIC_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fsw_req_if req_bus ();
   fsw_rsp_if rsp_bus ();

   fourier_series_waveform_eval dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   logic [HC_W-1:0]  harmonics = HC_RESET;
   logic [IRC_W-1:0] inv_rc = IRC_RESET;
   wave_word_type    wave_pending[$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               hold_off = 0;
   bit               calm = 1'b0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.time_phase = '0;
      rsp_bus.ready = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sine and cosine of a 32-bit turn angle, q30
   function automatic void cordic_sin_cos(input logic [31:0] angle,
                                          output longint s, output longint c);
      longint x, y, z, nx;
      bit     flip;
      logic [31:0] a;
      logic [31:0] probe;
      a = angle;
      probe = a + 32'h4000_0000;
      flip = probe[31];
      if (flip) a = a + 32'h8000_0000;
      x = CORDIC_K;
      y = 0;
      z = longint'($signed(a));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arc_step(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arc_step(i);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic wave_word_type eval_waveform(input logic [TIME_W-1:0] t);
      wave_word_type w;
      longint acc_sq, acc_int, sn, cs, sq, p, iv, n;
      int count;
      logic [31:0] angle;
      logic [15:0] ph;
      acc_sq = 0;
      acc_int = 0;
      count = (harmonics > 32) ? 32 : int'(harmonics);
      for (int k = 1; k <= count; k += 2) begin
         n = k;
         ph = 16'(k * int'(t));
         angle = {ph, 16'h0000};
         cordic_sin_cos(angle, sn, cs);
         if ((k & 3) == 1) begin
            acc_sq += cs / n;
            acc_int += sn / (n * n);
         end else begin
            acc_sq -= cs / n;
            acc_int -= sn / (n * n);
         end
      end
      sq = (acc_sq * 64'sd5340354 + (64'sd1 <<< 37)) >>> 38;
      if (sq > 524287) sq = 524287;
      if (sq < -524288) sq = -524288;
      p = (acc_int * 64'sd1699887 + (64'sd1 <<< 19)) >>> 20;
      iv = (p * longint'(inv_rc) + (64'sd1 <<< 17)) >>> 18;
      if (iv > 64'sd2147483647) iv = 64'sd2147483647;
      if (iv < -64'sd2147483648) iv = -64'sd2147483648;
      w.square_value = sq[SQ_W-1:0];
      w.integrated_value = iv[IV_W-1:0];
      return w;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** fourier_series_waveform_eval: FAILED **");
         $finish;
      end
   end

   // receiver side
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      wave_word_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (wave_pending.size() == 0) begin
            $error("unexpected word: square_value %0d integrated_value %0d",
                   rsp_bus.square_value, rsp_bus.integrated_value);
            error_count++;
         end else begin
            w = wave_pending.pop_front();
            if (rsp_bus.square_value !== w.square_value) begin
               $error("square_value: expected %0d actual %0d",
                      w.square_value, rsp_bus.square_value);
               error_count++;
            end
            if (rsp_bus.integrated_value !== w.integrated_value) begin
               $error("integrated_value: expected %0d actual %0d",
                      w.integrated_value, rsp_bus.integrated_value);
               error_count++;
            end
         end
      end
   end

   task automatic send_word(input logic [TIME_W-1:0] t);
      while (!calm && $urandom_range(99) < 19) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.time_phase <= t;
      do @(posedge clock); while (!req_bus.ready);
      wave_pending.push_back(eval_waveform(t));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (wave_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HARMONIC_COUNT) harmonics = value[HC_W-1:0];
      else inv_rc = value[IRC_W-1:0];
   endtask

   task automatic send_corner_phases();
      logic [TIME_W-1:0] corners[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                        16'hC000, 16'h0001, 16'h5555, 16'hAAAA};
      foreach (corners[i]) send_word(corners[i]);
   endtask

   task automatic test_reset_values();
      send_corner_phases();
   endtask

   task automatic test_harmonic_extremes();
      int counts[5] = '{0, 1, 32, 63, 3};
      foreach (counts[i]) begin
         write_csr(CSR_HARMONIC_COUNT, counts[i]);
         send_word(16'h0000);
         send_word(16'hFFFF);
         send_word(16'h2000);
      end
   endtask

   task automatic test_inverse_rc_extremes();
      write_csr(CSR_HARMONIC_COUNT, 32);
      write_csr(CSR_INVERSE_RC, 0);
      send_word(16'h4000);
      write_csr(CSR_INVERSE_RC, 65535);
      send_corner_phases();
      write_csr(CSR_INVERSE_RC, 1);
      send_word(16'hC000);
   endtask

   task automatic test_backpressure();
      write_csr(CSR_INVERSE_RC, 100);
      hold_off = 300;
      repeat (80) send_word(16'($urandom_range(65535)));
   endtask

   task automatic test_random();
      int hc_set[6] = '{20, 32, 1, 63, 0, 17};
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_HARMONIC_COUNT, (phase < 5) ? hc_set[phase]
                                                   : $urandom_range(63));
         write_csr(CSR_INVERSE_RC, (phase == 1) ? 65535 : $urandom_range(65535));
         calm = (phase == 2);
         repeat (160) send_word(16'($urandom_range(65535)));
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_harmonic_extremes();
      test_inverse_rc_extremes();
      test_backpressure();
      test_random();
      wait_idle();
      if (error_count == 0) begin
         $display("** fourier_series_waveform_eval: PASSED **");
      end else begin
         $display("** fourier_series_waveform_eval: FAILED **");
      end
      $finish;
   end

endmodule
